>>> design/assert_macros.svh
// assertion helpers used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define SLPG_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define SLPG_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/slpg_pkg.sv
package slpg_pkg;

  localparam int COORD_BITS    = 11;
  localparam int SIZE_BITS     = 12;
  localparam int MODE_BITS     = 6;
  localparam int DEPTH_BITS    = 4;
  localparam int GRAY_BITS     = SIZE_BITS + 1;
  localparam int FRINGE_PERIOD = 30;
  localparam int PHASE_STEP    = FRINGE_PERIOD / 3;
  localparam int IDX_BITS      = $clog2(FRINGE_PERIOD);

  // configuration register indexes
  localparam logic [1:0] CFG_MODE   = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  // pattern mode codes
  localparam logic [MODE_BITS-1:0] MODE_HFRINGE_LAST = 6'd2;
  localparam logic [MODE_BITS-1:0] MODE_VFRINGE_0    = 6'd3;
  localparam logic [MODE_BITS-1:0] MODE_VFRINGE_LAST = 6'd5;
  localparam logic [MODE_BITS-1:0] MODE_HCENTER      = 6'd6;
  localparam logic [MODE_BITS-1:0] MODE_VCENTER      = 6'd7;
  localparam logic [MODE_BITS-1:0] MODE_BLACK        = 6'd8;
  localparam logic [MODE_BITS-1:0] MODE_RGBH         = 6'd9;
  localparam logic [MODE_BITS-1:0] MODE_RGBV         = 6'd10;
  localparam logic [MODE_BITS-1:0] MODE_GRAYH_0      = 6'd12;
  localparam logic [MODE_BITS-1:0] MODE_GRAYH_LAST   = 6'd21;
  localparam logic [MODE_BITS-1:0] MODE_GRAYV_0      = 6'd22;
  localparam logic [MODE_BITS-1:0] MODE_GRAYV_LAST   = 6'd31;

  localparam logic [SIZE_BITS-1:0]  RESET_WIDTH  = 12'd608;
  localparam logic [SIZE_BITS-1:0]  RESET_HEIGHT = 12'd684;
  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX    = 4'(SIZE_BITS);

  localparam logic [7:0] LEVEL_ON  = 8'd255;
  localparam logic [7:0] LEVEL_OFF = 8'd0;

  // floor(127.5 * (1 + cos(2*pi*n/30)))
  localparam logic [7:0] COS_LUT [FRINGE_PERIOD] = '{
    8'd255, 8'd252, 8'd243, 8'd230, 8'd212, 8'd191, 8'd166, 8'd140, 8'd114, 8'd88,
    8'd63,  8'd42,  8'd24,  8'd11,  8'd2,   8'd0,   8'd2,   8'd11,  8'd24,  8'd42,
    8'd63,  8'd88,  8'd114, 8'd140, 8'd166, 8'd191, 8'd212, 8'd230, 8'd243, 8'd252
  };

  typedef struct packed {
    logic [DEPTH_BITS-1:0] depth;
    logic [SIZE_BITS-1:0]  offset;
  } gray_cfg_t;

endpackage

>>> design/structured_light_pattern_generator.sv
// channel  dir  signals                    word layout (lsb first)
// in_      in   tvalid tready tdata[23:0]  pixel_x[10:0] pixel_y[21:11]
// out_     out  tvalid tready tdata[23:0]  red[7:0] green[15:8] blue[23:16]
// cfg_     in   we index[1:0] data[11:0]   0 pattern_mode, 1 screen_width, 2 screen_height
//
// one word per cycle while the output is ready; an input register, then
// the fringe table lookup or gray plane select, then the output register.
// a stalled output holds both stages; in_tready drops only when both are full.
// rst_n is synchronous; it clears the valid flags and reloads the configuration registers.
// derived gray depth and centering offsets are updated on the cfg write itself.
module structured_light_pattern_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // pixel_x, pixel_y
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // red, green, blue
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);
  import slpg_pkg::*;

  `include "assert_macros.svh"

  function automatic logic [DEPTH_BITS-1:0] code_depth(
    input logic [SIZE_BITS-1:0] w,
    input logic [SIZE_BITS-1:0] h
  );
    logic [SIZE_BITS-1:0]  m;
    logic [SIZE_BITS-1:0]  v;
    logic [DEPTH_BITS-1:0] d;
    m = (w > h) ? w : h;
    v = m - SIZE_BITS'(1);
    d = '0;
    if (m > SIZE_BITS'(1)) begin
      for (int i = 0; i < SIZE_BITS; i++) begin
        if (v[i]) d = DEPTH_BITS'(i + 1);
      end
    end
    return d;
  endfunction

  function automatic logic [SIZE_BITS-1:0] center_offset(
    input logic [DEPTH_BITS-1:0] d,
    input logic [SIZE_BITS-1:0]  size
  );
    logic [GRAY_BITS-1:0] full;
    logic [GRAY_BITS-1:0] diff;
    full = GRAY_BITS'(1) << d;
    diff = full - GRAY_BITS'(size);
    return diff[GRAY_BITS-1:1];
  endfunction

  // configuration
  logic [MODE_BITS-1:0]  mode_r, mode_nxt;
  logic [SIZE_BITS-1:0]  width_r, width_nxt;
  logic [SIZE_BITS-1:0]  height_r, height_nxt;
  logic [DEPTH_BITS-1:0] depth_r, depth_nxt;
  logic [SIZE_BITS-1:0]  off_h_r, off_v_r;

  always_comb begin
    mode_nxt   = mode_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:   mode_nxt   = cfg_data[MODE_BITS-1:0];
        CFG_WIDTH:  width_nxt  = cfg_data;
        CFG_HEIGHT: height_nxt = cfg_data;
        default: ;
      endcase
    end
    depth_nxt = code_depth(width_nxt, height_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= '0;
      width_r  <= RESET_WIDTH;
      height_r <= RESET_HEIGHT;
      depth_r  <= code_depth(RESET_WIDTH, RESET_HEIGHT);
      off_h_r  <= center_offset(code_depth(RESET_WIDTH, RESET_HEIGHT), RESET_HEIGHT);
      off_v_r  <= center_offset(code_depth(RESET_WIDTH, RESET_HEIGHT), RESET_WIDTH);
    end else begin
      mode_r   <= mode_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      depth_r  <= depth_nxt;
      off_h_r  <= center_offset(depth_nxt, height_nxt);
      off_v_r  <= center_offset(depth_nxt, width_nxt);
    end
  end

  // pipeline control
  logic                  s1_valid_r;
  logic [COORD_BITS-1:0] s1_x_r, s1_y_r;
  logic                  out_valid_r;
  logic [23:0]           out_rgb_r, out_rgb_nxt;
  logic                  advance;

  assign advance    = !out_valid_r || out_tready;
  assign in_tready  = !s1_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_rgb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) s1_valid_r <= in_tvalid;
      if (advance) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_x_r <= in_tdata[COORD_BITS-1:0];
      s1_y_r <= in_tdata[2*COORD_BITS-1:COORD_BITS];
    end
    if (advance && s1_valid_r) out_rgb_r <= out_rgb_nxt;
  end

  // pattern datapath
  logic                  fringe_on_y;
  logic [COORD_BITS-1:0] fringe_coord;
  logic [2:0][7:0]       fringe_level;
  logic [1:0]            phase;
  logic                  gray_vert;
  gray_cfg_t             gray_cfg;
  logic [MODE_BITS-1:0]  plane_full;
  logic                  gray_lit;
  logic [7:0]            lvl;

  assign fringe_on_y  = (mode_r <= MODE_HFRINGE_LAST) || (mode_r == MODE_RGBH);
  assign fringe_coord = fringe_on_y ? s1_y_r : s1_x_r;
  assign phase        = (mode_r <= MODE_HFRINGE_LAST) ? mode_r[1:0]
                                                      : 2'(mode_r - MODE_VFRINGE_0);

  slpg_fringe u_fringe (
    .coord (fringe_coord),
    .level (fringe_level)
  );

  assign gray_vert       = mode_r >= MODE_GRAYV_0;
  assign gray_cfg.depth  = depth_r;
  assign gray_cfg.offset = gray_vert ? off_v_r : off_h_r;
  assign plane_full      = gray_vert ? (mode_r - MODE_GRAYV_0) : (mode_r - MODE_GRAYH_0);

  slpg_gray u_gray (
    .coord (gray_vert ? s1_x_r : s1_y_r),
    .cfg   (gray_cfg),
    .plane (plane_full[3:0]),
    .lit   (gray_lit)
  );

  always_comb begin
    lvl         = LEVEL_ON;
    out_rgb_nxt = '0;
    priority if (mode_r <= MODE_VFRINGE_LAST) begin
      lvl = fringe_level[phase];
    end else if (mode_r == MODE_HCENTER) begin
      lvl = (SIZE_BITS'(s1_y_r) == (height_r >> 1)) ? LEVEL_ON : LEVEL_OFF;
    end else if (mode_r == MODE_VCENTER) begin
      lvl = (SIZE_BITS'(s1_x_r) == (width_r >> 1)) ? LEVEL_ON : LEVEL_OFF;
    end else if (mode_r == MODE_BLACK) begin
      lvl = LEVEL_OFF;
    end else if (mode_r >= MODE_GRAYH_0 && mode_r <= MODE_GRAYV_LAST) begin
      lvl = gray_lit ? LEVEL_ON : LEVEL_OFF;
    end else begin
      lvl = LEVEL_ON;
    end
    if (mode_r == MODE_RGBH || mode_r == MODE_RGBV) begin
      out_rgb_nxt = {fringe_level[2], fringe_level[1], fringe_level[0]};
    end else begin
      out_rgb_nxt = {lvl, lvl, lvl};
    end
  end

  `SLPG_ASSERT(a_mono_channels, clk, rst_n,
    out_valid_r && mode_r != MODE_RGBH && mode_r != MODE_RGBV |->
      out_rgb_r[7:0] == out_rgb_r[15:8] && out_rgb_r[15:8] == out_rgb_r[23:16],
    "single-channel pattern produced unequal channels")
  `SLPG_ASSERT(a_stage_holds, clk, rst_n,
    s1_valid_r && !advance |=> s1_valid_r,
    "input stage dropped a word while the output was stalled")
  `SLPG_ASSERT(a_accept_loads, clk, rst_n,
    in_tvalid && in_tready |=> s1_valid_r,
    "accepted word did not reach the input stage")
  `SLPG_ASSERT(a_depth_range, clk, rst_n,
    depth_r <= DEPTH_MAX,
    "gray code depth out of range")
  `SLPG_ASSERT_ALWAYS(a_reset_empty, clk,
    !rst_n |=> !out_valid_r && !s1_valid_r,
    "pipeline not empty after reset")

endmodule

>>> design/slpg_fringe.sv
module slpg_fringe (
  input  logic [slpg_pkg::COORD_BITS-1:0] coord,
  output logic [2:0][7:0]                 level
);
  import slpg_pkg::*;

  localparam int RECIP_SHIFT = 17;
  localparam int RECIP       = (1 << RECIP_SHIFT) / FRINGE_PERIOD + 1;
  localparam int RECIP_BITS  = $clog2(RECIP + 1);
  localparam int PROD_BITS   = COORD_BITS + RECIP_BITS;

  logic [PROD_BITS-1:0]   prod;
  logic [COORD_BITS-1:0]  quot;
  logic [COORD_BITS-1:0]  rem_full;
  logic [IDX_BITS-1:0]    rem;

  // coord mod period by reciprocal multiply, exact over the coordinate range
  assign prod     = PROD_BITS'(coord) * PROD_BITS'(RECIP);
  assign quot     = COORD_BITS'(prod >> RECIP_SHIFT);
  assign rem_full = coord - COORD_BITS'(quot * COORD_BITS'(FRINGE_PERIOD));
  assign rem      = rem_full[IDX_BITS-1:0];

  always_comb begin
    logic [IDX_BITS:0] idx;
    for (int p = 0; p < 3; p++) begin
      idx = {1'b0, rem} + (IDX_BITS+1)'(p * PHASE_STEP);
      if (idx >= (IDX_BITS+1)'(FRINGE_PERIOD)) begin
        idx = idx - (IDX_BITS+1)'(FRINGE_PERIOD);
      end
      level[p] = COS_LUT[idx[IDX_BITS-1:0]];
    end
  end

endmodule

>>> design/slpg_gray.sv
module slpg_gray (
  input  logic [slpg_pkg::COORD_BITS-1:0] coord,
  input  slpg_pkg::gray_cfg_t             cfg,
  input  logic [3:0]                      plane,
  output logic                            lit
);
  import slpg_pkg::*;

  logic [GRAY_BITS-1:0]  c;
  logic [GRAY_BITS-1:0]  g;
  logic [DEPTH_BITS-1:0] bit_sel;
  logic                  too_deep;

  assign c        = GRAY_BITS'(coord) + GRAY_BITS'(cfg.offset);
  assign g        = c ^ (c >> 1);
  assign too_deep = {1'b0, plane} >= {1'b0, cfg.depth};
  // plane 0 is the most significant code bit
  assign bit_sel  = cfg.depth - DEPTH_BITS'(1) - plane;
  assign lit      = too_deep ? 1'b0 : g[bit_sel];

endmodule

>>> tb/sv/slpg_pixel_checker.sv
module slpg_pixel_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // pixel_x, pixel_y
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // red, green, blue
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data,
  output int          fail_count,
  output int          outstanding,
  output int          pixels_checked
);
  import slpg_pkg::*;

  typedef struct {
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
    logic [MODE_BITS-1:0]  mode;
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
  } pixel_expect_t;

  // one period of the truncated raised cosine
  localparam logic [7:0] FRINGE_WAVE [FRINGE_PERIOD] = '{
    8'd255, 8'd252, 8'd243, 8'd230, 8'd212, 8'd191, 8'd166, 8'd140, 8'd114, 8'd88,
    8'd63,  8'd42,  8'd24,  8'd11,  8'd2,   8'd0,   8'd2,   8'd11,  8'd24,  8'd42,
    8'd63,  8'd88,  8'd114, 8'd140, 8'd166, 8'd191, 8'd212, 8'd230, 8'd243, 8'd252
  };

  logic [MODE_BITS-1:0] mode_q;
  logic [SIZE_BITS-1:0] width_q;
  logic [SIZE_BITS-1:0] height_q;
  pixel_expect_t        expected_pixels [$];

  initial begin
    fail_count     = 0;
    outstanding    = 0;
    pixels_checked = 0;
  end

  function automatic logic [7:0] fringe_level(input int unsigned coord, input int unsigned phase);
    return FRINGE_WAVE[(coord + phase * FRINGE_PERIOD / 3) % FRINGE_PERIOD];
  endfunction

  function automatic logic [7:0] gray_level(input int unsigned coord, input int unsigned size,
                                            input int unsigned plane, input int unsigned w,
                                            input int unsigned h);
    int unsigned widest;
    int unsigned depth;
    int unsigned ofs;
    int unsigned code;
    widest = (w > h) ? w : h;
    depth  = 0;
    while (depth < 31 && (32'd1 << depth) < widest) depth++;
    if (plane + 1 > depth) return LEVEL_OFF;
    ofs  = ((32'd1 << depth) >= size) ? ((32'd1 << depth) - size) / 2 : 0;
    code = coord + ofs;
    code = code ^ (code >> 1);
    return ((code >> (depth - 1 - plane)) & 1) ? LEVEL_ON : LEVEL_OFF;
  endfunction

  function automatic pixel_expect_t pattern_pixel(input logic [COORD_BITS-1:0] px,
                                                  input logic [COORD_BITS-1:0] py,
                                                  input logic [MODE_BITS-1:0] mode,
                                                  input logic [SIZE_BITS-1:0] w,
                                                  input logic [SIZE_BITS-1:0] h);
    pixel_expect_t p;
    logic [7:0]    level;
    p.mode = mode;
    p.px   = px;
    p.py   = py;
    level  = LEVEL_ON;
    if (mode <= MODE_HFRINGE_LAST) begin
      level = fringe_level(py, mode);
    end else if (mode <= MODE_VFRINGE_LAST) begin
      level = fringe_level(px, mode - MODE_VFRINGE_0);
    end else if (mode == MODE_HCENTER) begin
      level = (py == h / 2) ? LEVEL_ON : LEVEL_OFF;
    end else if (mode == MODE_VCENTER) begin
      level = (px == w / 2) ? LEVEL_ON : LEVEL_OFF;
    end else if (mode == MODE_BLACK) begin
      level = LEVEL_OFF;
    end else if (mode >= MODE_GRAYH_0 && mode <= MODE_GRAYH_LAST) begin
      level = gray_level(py, h, mode - MODE_GRAYH_0, w, h);
    end else if (mode >= MODE_GRAYV_0 && mode <= MODE_GRAYV_LAST) begin
      level = gray_level(px, w, mode - MODE_GRAYV_0, w, h);
    end
    p.red   = level;
    p.green = level;
    p.blue  = level;
    // the packed fringe modes carry one phase per channel
    if (mode == MODE_RGBH) begin
      p.red   = fringe_level(py, 0);
      p.green = fringe_level(py, 1);
      p.blue  = fringe_level(py, 2);
    end else if (mode == MODE_RGBV) begin
      p.red   = fringe_level(px, 0);
      p.green = fringe_level(px, 1);
      p.blue  = fringe_level(px, 2);
    end
    return p;
  endfunction

  always @(posedge clk) begin : watch
    pixel_expect_t want;
    int            miss;
    miss = 0;
    if (!rst_n) begin
      mode_q   <= '0;
      width_q  <= RESET_WIDTH;
      height_q <= RESET_HEIGHT;
      expected_pixels.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODE:   mode_q   <= cfg_data[MODE_BITS-1:0];
          CFG_WIDTH:  width_q  <= cfg_data[SIZE_BITS-1:0];
          CFG_HEIGHT: height_q <= cfg_data[SIZE_BITS-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        expected_pixels.push_back(pattern_pixel(in_tdata[10:0], in_tdata[21:11],
                                                mode_q, width_q, height_q));
      if (out_tvalid && out_tready) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: pixel word %h with none expected", $time, out_tdata);
          miss = 1;
        end else begin
          want = expected_pixels.pop_front();
          if (out_tdata[7:0] !== want.red) begin
            $display("%0t: red mismatch mode %0d x %0d y %0d: expected %0d, got %0d",
                     $time, want.mode, want.px, want.py, want.red, out_tdata[7:0]);
            miss = 1;
          end
          if (out_tdata[15:8] !== want.green) begin
            $display("%0t: green mismatch mode %0d x %0d y %0d: expected %0d, got %0d",
                     $time, want.mode, want.px, want.py, want.green, out_tdata[15:8]);
            miss = 1;
          end
          if (out_tdata[23:16] !== want.blue) begin
            $display("%0t: blue mismatch mode %0d x %0d y %0d: expected %0d, got %0d",
                     $time, want.mode, want.px, want.py, want.blue, out_tdata[23:16]);
            miss = 1;
          end
          pixels_checked <= pixels_checked + 1;
        end
      end
    end
    fail_count  <= fail_count + miss;
    outstanding <= expected_pixels.size();
  end

endmodule

>>> tb/sv/tb_structured_light_pattern_generator.sv
module tb_structured_light_pattern_generator;
  import slpg_pkg::*;

  localparam int unsigned RANDOM_PIXELS = 1600;
  localparam int unsigned CALM_TAIL     = 250;
  localparam int unsigned HOLD_CYCLES   = 150;
  localparam int unsigned TIMEOUT       = 4_000_000;

  localparam logic [MODE_BITS-1:0] MODE_HFRINGE_0 = 6'd0;
  localparam logic [MODE_BITS-1:0] MODE_WHITE     = 6'd11;
  localparam logic [MODE_BITS-1:0] MODE_SPARE_LO  = 6'd32;
  localparam logic [MODE_BITS-1:0] MODE_SPARE_HI  = 6'd63;
  localparam logic [1:0]           CFG_SPARE      = 2'd3;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [23:0] in_tdata   = '0;    // pixel_x[10:0], pixel_y[21:11]
  logic        out_tready = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_index  = CFG_MODE;
  logic [11:0] cfg_data   = '0;
  logic        in_tready;
  logic        out_tvalid;
  logic [23:0] out_tdata;          // red[7:0], green[15:8], blue[23:16]

  int fail_count;
  int outstanding;
  int pixels_checked;
  int pixels_sent     = 0;
  int settings_loaded = 0;
  int idle_pct        = 0;
  int sink_left       = 0;
  bit calm            = 1'b0;
  bit hold_req        = 1'b0;
  bit hold_done       = 1'b0;

  always #4 clk = ~clk;

  structured_light_pattern_generator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  slpg_pixel_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .outstanding    (outstanding),
    .pixels_checked (pixels_checked)
  );

  // output side: random stall bursts plus one long hold to back up the pipe
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      sink_left  <= 0;
    end else if (hold_req && !hold_done) begin
      out_tready <= 1'b0;
      sink_left  <= HOLD_CYCLES - 1;
      hold_done  <= 1'b1;
    end else if (sink_left != 0) begin
      out_tready <= 1'b0;
      sink_left  <= sink_left - 1;
    end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
      out_tready <= 1'b0;
      sink_left  <= $urandom_range(0, 18);
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [11:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic load_projection(input logic [11:0] mode_word, input logic [11:0] w,
                                 input logic [11:0] h, input bit poke_spare);
    wait_idle();
    write_reg(CFG_MODE, mode_word);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    if (poke_spare) write_reg(CFG_SPARE, 12'($urandom));
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  task automatic send_pixel(input logic [COORD_BITS-1:0] px, input logic [COORD_BITS-1:0] py);
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, py, px};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pixels_sent++;
  endtask

  function automatic logic [COORD_BITS-1:0] pick_coord(input int unsigned size);
    int unsigned span;
    span = (size > 2048) ? 2048 : size;
    case ($urandom_range(0, 9))
      0:       return COORD_BITS'(size / 2);
      1:       return $urandom_range(0, 1) ? '1 : '0;
      2, 3:    return (span == 0) ? '0 : COORD_BITS'($urandom_range(0, span - 1));
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [SIZE_BITS-1:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return 12'd1;
      1:       return 12'd2048;
      2:       return 12'd0;
      3:       return 12'($urandom);
      4:       return 12'($urandom_range(2, 40));
      default: return 12'($urandom_range(1, 2048));
    endcase
  endfunction

  initial begin : stimulus
    logic [MODE_BITS-1:0] mode;
    logic [SIZE_BITS-1:0] w;
    logic [SIZE_BITS-1:0] h;
    int unsigned          phase;
    int unsigned          target;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_pct = 25;
    // reset settings first
    send_pixel('0, '0);
    send_pixel('1, '1);
    load_projection({6'd0, MODE_HFRINGE_0 + 6'd2}, 12'd608, 12'd684, 1'b0);
    send_pixel(11'd0, 11'd2047);
    load_projection({6'd0, MODE_VFRINGE_0 + 6'd1}, 12'd608, 12'd684, 1'b0);
    send_pixel(11'd2047, 11'd0);
    send_pixel(11'd29, 11'd5);
    load_projection({6'd0, MODE_HCENTER}, 12'd608, 12'd684, 1'b1);
    send_pixel(11'd5, 11'd342);
    send_pixel(11'd5, 11'd343);
    // zero size puts the line at 0
    load_projection({6'd0, MODE_VCENTER}, 12'd0, 12'd684, 1'b0);
    send_pixel(11'd0, 11'd9);
    load_projection({6'd0, MODE_HCENTER}, 12'd0, 12'd0, 1'b0);
    send_pixel(11'd3, 11'd0);
    load_projection({6'd0, MODE_BLACK}, 12'd2048, 12'd2048, 1'b0);
    send_pixel(11'd2047, 11'd2047);
    load_projection({6'd0, MODE_RGBH}, 12'd1, 12'd1, 1'b0);
    send_pixel(11'd3, 11'd17);
    load_projection({6'd0, MODE_RGBV}, 12'd4095, 12'd4095, 1'b0);
    send_pixel(11'd1234, 11'd5);
    load_projection({6'd0, MODE_WHITE}, 12'd608, 12'd684, 1'b0);
    send_pixel(11'd0, 11'd0);
    load_projection({6'd0, MODE_GRAYH_0}, 12'd608, 12'd684, 1'b0);
    send_pixel(11'd0, 11'd683);
    load_projection({6'd0, MODE_GRAYH_LAST}, 12'd608, 12'd684, 1'b0);
    send_pixel(11'd7, 11'd341);
    // no code depth at all, then a plane deeper than the code
    load_projection({6'd0, MODE_GRAYV_0}, 12'd1, 12'd1, 1'b0);
    send_pixel(11'd0, 11'd0);
    load_projection({6'd0, MODE_GRAYV_LAST}, 12'd4, 12'd2, 1'b0);
    send_pixel(11'd3, 11'd0);
    // coordinate far past the code range
    load_projection({6'd0, MODE_GRAYV_0 + 6'd3}, 12'd16, 12'd16, 1'b0);
    send_pixel(11'd2047, 11'd0);
    load_projection({6'd0, MODE_SPARE_LO}, 12'd0, 12'd0, 1'b0);
    send_pixel(11'd1, 11'd1);
    load_projection({6'h3f, MODE_SPARE_HI}, 12'd608, 12'd684, 1'b0);
    send_pixel(11'd1024, 11'd512);

    target = pixels_sent + RANDOM_PIXELS;
    phase  = 0;
    while (pixels_sent < target) begin
      mode = ($urandom_range(0, 7) == 0) ? MODE_BITS'($urandom_range(32, 63))
                                         : MODE_BITS'($urandom_range(0, 31));
      w = pick_size();
      h = pick_size();
      idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      load_projection({6'($urandom), mode}, w, h, $urandom_range(0, 3) == 0);
      if (phase == 3) hold_req = 1'b1;
      repeat ($urandom_range(20, 70)) begin
        if (pixels_sent + CALM_TAIL >= target) calm = 1'b1;
        send_pixel(pick_coord(w), pick_coord(h));
      end
      phase++;
    end

    wait_idle();
    repeat (8) @(posedge clk);
    $display("%0d pixels checked over %0d register settings: fringe, center line, fill",
             pixels_checked, settings_loaded);
    $display("and gray plane modes under random gaps, output stalls and one long hold");
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT);
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> structured_light_pattern_generator.f
+incdir+design
design/slpg_pkg.sv
design/slpg_fringe.sv
design/slpg_gray.sv
design/structured_light_pattern_generator.sv
tb/sv/slpg_pixel_checker.sv
tb/sv/tb_structured_light_pattern_generator.sv
